FILE: rtl/core/kmp_sm_pkg.sv
package kmp_sm_pkg;

   // Fixed field widths
   localparam int unsigned LEN_W  = 6;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned IDX_W  = 32;

   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [IDX_W-1:0]  idx_type;

   // Transaction kind on the request channel
   typedef enum logic {
      REQ_PATTERN = 1'b0,
      REQ_TEXT    = 1'b1
   } req_kind_type;

   // Controller states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_READ  = 3'b010,
      ST_CHECK = 3'b100
   } state_type;

   // Controller to store: one write and two reads per cycle
   typedef struct packed {
      logic     wr_en;
      len_type  wr_addr;
      byte_type wr_byte;
      len_type  wr_link;
      len_type  rd_byte_addr;
      len_type  rd_link_addr;
   } store_cmd_type;

   // Store to controller: registered read data
   typedef struct packed {
      byte_type rd_byte;
      len_type  rd_link;
   } store_data_type;

endpackage

FILE: rtl/core/kmp_sm_store.sv
module kmp_sm_store #(
   parameter int unsigned MAX_PATTERN = 32
) (
   input  logic                       clock,
   input  kmp_sm_pkg::store_cmd_type  cmd,
   output kmp_sm_pkg::store_data_type rd
);
   import kmp_sm_pkg::*;

   localparam int unsigned ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   byte_type byte_mem [MAX_PATTERN];
   len_type  link_mem [MAX_PATTERN];

   byte_type rd_byte_ff;
   len_type  rd_link_ff;

   // Write pattern byte and its failure link together; read data of both is registered
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         byte_mem[cmd.wr_addr[ADDR_W-1:0]] <= cmd.wr_byte;
         link_mem[cmd.wr_addr[ADDR_W-1:0]] <= cmd.wr_link;
      end
      rd_byte_ff <= byte_mem[cmd.rd_byte_addr[ADDR_W-1:0]];
      rd_link_ff <= link_mem[cmd.rd_link_addr[ADDR_W-1:0]];
   end

   assign rd.rd_byte = rd_byte_ff;
   assign rd.rd_link = rd_link_ff;

endmodule

FILE: rtl/core/kmp_substring_matcher_core.sv
// Streaming Knuth-Morris-Pratt substring search. Send pattern bytes (req_type = 0)
// first, marking the final one with req_last_of_run; then stream text bytes
// (req_type = 1). Each time a full match ends on a text byte, one transaction
// carrying the text index of the match's first byte appears on rsp_*; overlapping
// matches are all reported. Only the first MAX_PATTERN pattern bytes are kept, an
// empty pattern reports nothing, and any pattern byte restarts the text at index 0.
// One transaction is in flight at a time. A transaction is accepted in ST_IDLE,
// then passes through ST_READ and ST_CHECK once, and once more per failure-link
// step: each step is one read of the pattern and link memories (registered read
// data, in ST_READ) followed by one compare in ST_CHECK. The first pattern byte,
// and text bytes with an empty pattern, finish in ST_IDLE. A result held by
// rsp_stall keeps the next text result waiting, but the next transaction is still
// accepted.
module kmp_substring_matcher_core #(
   parameter int unsigned MAX_PATTERN = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  kmp_sm_pkg::byte_type         req_data_byte,
   input  logic                         req_last_of_run,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output kmp_sm_pkg::idx_type          rsp_match_start
);
   import kmp_sm_pkg::*;

   localparam len_type MAX_LEN = LEN_W'(MAX_PATTERN);

   state_type      state_ff, state_in;
   len_type        plen_ff, plen_in;
   len_type        bpl_ff, bpl_in;
   len_type        matched_ff, matched_in;
   idx_type        text_idx_ff, text_idx_in;
   logic           pat_closed_ff, pat_closed_in;
   logic           txt_closed_ff, txt_closed_in;
   len_type        k_ff, k_in;
   req_kind_type   kind_ff, kind_in;
   byte_type       byte_ff, byte_in;
   idx_type        start_ff, start_in;
   logic           rsp_valid_ff, rsp_valid_in;
   idx_type        rsp_start_ff, rsp_start_in;

   store_cmd_type  cmd;
   store_data_type store_rd;

   kmp_sm_store #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_store (
      .clock(clock),
      .cmd  (cmd),
      .rd   (store_rd)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_start = rsp_start_ff;

   // Next-state logic: accept, walk failure links, finish
   always_comb begin
      len_type plen_eff;
      len_type bpl_eff;
      len_type matched_eff;
      idx_type idx_eff;
      logic    force_miss;
      logic    hit;
      len_type k_done;

      state_in      = state_ff;
      plen_in       = plen_ff;
      bpl_in        = bpl_ff;
      matched_in    = matched_ff;
      text_idx_in   = text_idx_ff;
      pat_closed_in = pat_closed_ff;
      txt_closed_in = txt_closed_ff;
      k_in          = k_ff;
      kind_in       = kind_ff;
      byte_in       = byte_ff;
      start_in      = start_ff;
      rsp_start_in  = rsp_start_ff;

      plen_eff    = pat_closed_ff ? '0 : plen_ff;
      bpl_eff     = pat_closed_ff ? '0 : bpl_ff;
      matched_eff = txt_closed_ff ? '0 : matched_ff;
      idx_eff     = txt_closed_ff ? '0 : text_idx_ff;
      force_miss  = (k_ff >= plen_ff);
      hit         = !force_miss && (store_rd.rd_byte == byte_ff);
      k_done      = hit ? LEN_W'(k_ff + 1'b1) : '0;

      // Drop the output register once the transaction is taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      cmd.wr_en        = 1'b0;
      cmd.wr_addr      = plen_ff;
      cmd.wr_byte      = byte_ff;
      cmd.wr_link      = k_done;
      cmd.rd_byte_addr = k_ff;
      cmd.rd_link_addr = LEN_W'(k_ff - 1'b1);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               byte_in = req_data_byte;
               kind_in = req_kind_type'(req_type);
               if (req_kind_type'(req_type) == REQ_PATTERN) begin
                  // Pattern byte: restart text, append and build its link
                  plen_in       = plen_eff;
                  bpl_in        = bpl_eff;
                  pat_closed_in = req_last_of_run;
                  matched_in    = '0;
                  txt_closed_in = 1'b1;
                  if (plen_eff < MAX_LEN) begin
                     if (plen_eff == '0) begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = '0;
                        cmd.wr_byte = req_data_byte;
                        cmd.wr_link = '0;
                        plen_in     = LEN_W'(1);
                        bpl_in      = '0;
                     end else begin
                        k_in     = bpl_eff;
                        state_in = ST_READ;
                     end
                  end
               end else begin
                  // Text byte: advance index, search if a pattern is stored
                  matched_in    = matched_eff;
                  text_idx_in   = idx_eff + 1'b1;
                  txt_closed_in = req_last_of_run;
                  start_in      = idx_eff - IDX_W'(plen_ff) + 1'b1;
                  if (plen_ff != '0) begin
                     k_in     = matched_eff;
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!hit && (k_ff != '0)) begin
               // Mismatch: follow the failure link
               k_in     = store_rd.rd_link;
               state_in = ST_READ;
            end else if (kind_ff == REQ_PATTERN) begin
               cmd.wr_en = 1'b1;
               plen_in   = LEN_W'(plen_ff + 1'b1);
               bpl_in    = k_done;
               state_in  = ST_IDLE;
            end else begin
               matched_in = k_done;
               if (k_done != plen_ff) begin
                  state_in = ST_IDLE;
               end else if (!(rsp_valid_ff && rsp_stall)) begin
                  rsp_valid_in = 1'b1;
                  rsp_start_in = start_ff;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         plen_ff       <= '0;
         bpl_ff        <= '0;
         matched_ff    <= '0;
         text_idx_ff   <= '0;
         pat_closed_ff <= 1'b1;
         txt_closed_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         plen_ff       <= plen_in;
         bpl_ff        <= bpl_in;
         matched_ff    <= matched_in;
         text_idx_ff   <= text_idx_in;
         pat_closed_ff <= pat_closed_in;
         txt_closed_ff <= txt_closed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      kind_ff      <= kind_in;
      byte_ff      <= byte_in;
      start_ff     <= start_in;
      rsp_start_ff <= rsp_start_in;
   end

   // Partial match never exceeds the stored pattern
   assert property (@(posedge clock) disable iff (reset) matched_ff <= plen_ff)
      else $error("matched length exceeds pattern length");

   // Border of the stored pattern is a proper border
   assert property (@(posedge clock) disable iff (reset)
      (bpl_ff < plen_ff) || ((plen_ff == '0) && (bpl_ff == '0)))
      else $error("build prefix length not below pattern length");

   // Link walk stays within the stored pattern
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (k_ff <= plen_ff) && (plen_ff != '0))
      else $error("link walk index out of range");

   // A new result only comes from a text compare
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || !rsp_stall) ##1 rsp_valid_ff |->
         $past(state_ff == ST_CHECK) && $past(kind_ff == REQ_TEXT))
      else $error("result raised outside a text compare");

endmodule
